FILE: rtl/core/stlxd_pkg.sv
package stlxd_pkg;

    localparam int unsigned CFG_W       = 11;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned EVENT_W     = 3;
    localparam int unsigned FTYPE_W     = 2;
    localparam int unsigned LEN_RESET   = 248;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_RANGE  = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_CIR    = 8'h02;
    localparam logic [BYTE_W-1:0] XOR_INIT    = 8'h00;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORE  = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BAD     = 3'd4,
        EV_SWALLOW = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_SWALLOW = 3'd5
    } phase_t;

endpackage

FILE: rtl/core/stlxd_cfg.sv
module stlxd_cfg #(
    parameter int unsigned MAX_PAYLOAD = 1024,
    parameter int unsigned LW          = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [stlxd_pkg::CFG_W-1:0] cfg_wr_data,
    output logic [LW-1:0]               eff_len
);
    import stlxd_pkg::*;

    localparam int unsigned CMPW    = (LW > CFG_W) ? LW : CFG_W;
    localparam int unsigned RST_LEN = (LEN_RESET > MAX_PAYLOAD) ? MAX_PAYLOAD : LEN_RESET;
    localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_PAYLOAD);

    logic [LW-1:0]   len_reg;
    logic [LW-1:0]   len_next;
    logic [CMPW-1:0] wr_wide;

    // zero length acts as one, oversize saturates
    always_comb begin
        wr_wide = CMPW'(cfg_wr_data);
        if (wr_wide == '0) begin
            len_next = LW'(1);
        end else if (wr_wide > MAX_W) begin
            len_next = LW'(MAX_PAYLOAD);
        end else begin
            len_next = LW'(wr_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LW'(RST_LEN);
        end else if (cfg_wr_en) begin
            len_reg <= len_next;
        end
    end

    assign eff_len = len_reg;

endmodule

FILE: rtl/core/stlxd_parse.sv
module stlxd_parse #(
    parameter int unsigned CW = 10,
    parameter int unsigned LW = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [stlxd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [LW-1:0]                 eff_len,
    output stlxd_pkg::event_t             ev_kind,
    output logic [CW-1:0]                 pay_idx,
    output logic [stlxd_pkg::FTYPE_W-1:0] ftype
);
    import stlxd_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [BYTE_W-1:0]   xor_reg,    xor_next;
    logic [FTYPE_W-1:0]  ftype_reg,  ftype_next;
    logic [LW-1:0]       cnt_inc;
    logic                last_byte;

    assign cnt_inc   = LW'(cnt_reg) + LW'(1);
    assign last_byte = (cnt_inc >= eff_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            cnt_reg   <= '0;
            xor_reg   <= XOR_INIT;
            ftype_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            ftype_reg <= ftype_next;
        end
    end

    always_comb begin
        phase_next = PH_SYNC1;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        ftype_next = ftype_reg;
        ev_kind    = EV_IGNORE;
        pay_idx    = '0;
        case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                    ev_kind    = EV_HEADER;
                end
            end
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) begin
                    phase_next = PH_TYPE;
                    ev_kind    = EV_HEADER;
                end
            end
            PH_TYPE: begin
                if (rx_byte inside {TYPE_RANGE, TYPE_CIR}) begin
                    ftype_next = rx_byte[FTYPE_W-1:0];
                    cnt_next   = '0;
                    xor_next   = XOR_INIT;
                    phase_next = PH_PAYLOAD;
                    ev_kind    = EV_HEADER;
                end
            end
            PH_PAYLOAD: begin
                ev_kind  = EV_PAYLOAD;
                pay_idx  = cnt_reg;
                xor_next = xor_reg ^ rx_byte;
                if (last_byte) begin
                    cnt_next   = '0;
                    phase_next = PH_CHECK;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_CHECK: begin
                cnt_next = '0;
                if (rx_byte == xor_reg) begin
                    ev_kind = EV_GOOD;
                    // type 2 frames carry one trailing byte to drop
                    if (ftype_reg == TYPE_CIR[FTYPE_W-1:0]) begin
                        phase_next = PH_SWALLOW;
                    end
                end else begin
                    ev_kind = EV_BAD;
                end
            end
            PH_SWALLOW: begin
                ev_kind = EV_SWALLOW;
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    assign ftype = ftype_next;

endmodule

FILE: rtl/core/stlxd_obuf.sv
module stlxd_obuf #(
    parameter int unsigned DW = 23
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    logic          main_vld_reg;
    logic          skid_vld_reg;
    logic [DW-1:0] main_dat_reg;
    logic [DW-1:0] skid_dat_reg;
    logic          in_fire;

    assign in_ready = !skid_vld_reg;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (out_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (main_vld_reg && !out_ready) begin
                skid_vld_reg <= 1'b1;
            end
            main_vld_reg <= 1'b1;
        end else if (out_ready) begin
            main_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_ready) begin
                main_dat_reg <= skid_dat_reg;
            end
        end else if (in_fire) begin
            if (main_vld_reg && !out_ready) begin
                skid_dat_reg <= in_data;
            end else begin
                main_dat_reg <= in_data;
            end
        end
    end

    assign out_valid = main_vld_reg;
    assign out_data  = main_dat_reg;

endmodule

FILE: rtl/core/sync_type_length_xor_deframer_top.sv
// Byte-stream deframer: hunts for sync 0xAA 0x55, takes a type byte of 1 or 2, passes on
// payload_length payload words with their index while folding them into an XOR, then checks
// the next word against that XOR and reports the frame good or bad; after a good type-2 frame
// one more word is reported as swallowed. Every input word yields exactly one result word.
// Throughput is one word per clock while the buffer has room: the parser state updates in the
// cycle a word is taken and the result is registered in a two-entry output buffer, so s_ready
// stays high while one result waits and drops when both entries are full. cfg_wr_data of zero
// acts as one and values above MAX_PAYLOAD saturate; write it only while no word is in flight.
module sync_type_length_xor_deframer_top #(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [stlxd_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [stlxd_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [stlxd_pkg::EVENT_W-1:0]       m_event_kind,
    output logic [stlxd_pkg::BYTE_W-1:0]        m_data_byte,
    output logic [$clog2(MAX_PAYLOAD)-1:0]      m_payload_index,
    output logic [stlxd_pkg::FTYPE_W-1:0]       m_frame_type
);
    import stlxd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PAYLOAD);
    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned DW = EVENT_W + BYTE_W + CW + FTYPE_W;

    logic [LW-1:0]      eff_len;
    logic               in_fire;
    event_t             ev_kind;
    logic [CW-1:0]      pay_idx;
    logic [FTYPE_W-1:0] ftype;
    logic [DW-1:0]      res_in;
    logic [DW-1:0]      res_out;

    assign in_fire = s_valid && s_ready;

    stlxd_cfg #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LW          (LW)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .eff_len     (eff_len)
    );

    stlxd_parse #(
        .CW (CW),
        .LW (LW)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .rx_byte (s_rx_byte),
        .eff_len (eff_len),
        .ev_kind (ev_kind),
        .pay_idx (pay_idx),
        .ftype   (ftype)
    );

    assign res_in = {ev_kind, s_rx_byte, pay_idx, ftype};

    stlxd_obuf #(
        .DW (DW)
    ) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign {m_event_kind, m_data_byte, m_payload_index, m_frame_type} = res_out;

`ifndef SYNTHESIS
    // a word taken while the held result stalls must fill the skid entry
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && m_valid && !m_ready |=> !s_ready)
        else $error("skid entry not filled on stalled accept");

    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind != EV_PAYLOAD) |-> (m_payload_index == '0))
        else $error("payload index set on non-payload word");

    a_type_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_event_kind == EV_PAYLOAD) || (m_event_kind == EV_GOOD)
            || (m_event_kind == EV_BAD) || (m_event_kind == EV_SWALLOW))
        |-> (m_frame_type != '0))
        else $error("frame word without a frame type");
`endif

endmodule
